>>> rtl/fbcs_pkg.sv
package fbcs_pkg;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_ON    = 2'd1,
		PH_OFF   = 2'd2,
		PH_PAUSE = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		REG_ON_TIME    = 2'd0,
		REG_OFF_TIME   = 2'd1,
		REG_PAUSE_TIME = 2'd2
	} reg_index_t;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned CODE_W  = 8;
	localparam int unsigned INDEX_W = 2;

	localparam logic [TIME_W-1:0] RST_ON_TIME_US    = 32'd120000;
	localparam logic [TIME_W-1:0] RST_OFF_TIME_US   = 32'd120000;
	localparam logic [TIME_W-1:0] RST_PAUSE_TIME_US = 32'd600000;
	localparam logic [CODE_W-1:0] RST_LAST_CODE     = 8'd255;

	typedef struct packed {
		logic [TIME_W-1:0] on_time_us;
		logic [TIME_W-1:0] off_time_us;
		logic [TIME_W-1:0] pause_time_us;
	} timing_t;

	typedef struct packed {
		logic              code_seen;
		logic [CODE_W-1:0] last_code;
		logic [CODE_W-1:0] pulses_left;
		phase_t            seq_phase;
		logic [TIME_W-1:0] mark_time;
		logic              led_level;
	} seq_state_t;

endpackage

>>> rtl/fbcs_if.sv
interface fbcs_sample_if
	import fbcs_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] now_us;
	logic [CODE_W-1:0] fault_code;

	modport source (output valid, output now_us, output fault_code, input ready);
	modport sink (input valid, input now_us, input fault_code, output ready);
endinterface

interface fbcs_result_if;
	logic       valid;
	logic       ready;
	logic       led_on;
	logic [1:0] phase;

	modport source (output valid, output led_on, output phase, input ready);
	modport sink (input valid, input led_on, input phase, output ready);
endinterface

interface fbcs_cfg_if
	import fbcs_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [INDEX_W-1:0] index;
	logic [TIME_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/fault_blink_code_sequencer.sv
// Blinks a fault code on an LED as a group of pulses followed by a pause. One
// sample item is taken every clock cycle unless result.ready holds back a full
// result register; each gives one result item with the LED level and phase
// after that sample, held in the sample register, then offered from the result
// register. The sequencer state register sets the rate, taking one wrapping
// 32-bit subtract and compare per cycle. The user must write timing registers
// through cfg only while no sample is in flight; the block does not check it.
module fault_blink_code_sequencer
	import fbcs_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	fbcs_sample_if.sink    sample,
	fbcs_result_if.source  result,
	fbcs_cfg_if.sink       cfg
);

	logic              valid_s1;
	logic [TIME_W-1:0] now_s1;
	logic [CODE_W-1:0] code_s1;

	logic       valid_s2;
	logic       led_s2;
	logic [1:0] phase_s2;

	seq_state_t state_q;
	seq_state_t state_nxt;
	timing_t    timing_q;

	logic advance;
	logic take;

	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign take         = sample.valid && sample.ready;
	assign sample.ready = !valid_s1 || advance;
	assign cfg.ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.on_time_us    <= RST_ON_TIME_US;
			timing_q.off_time_us   <= RST_OFF_TIME_US;
			timing_q.pause_time_us <= RST_PAUSE_TIME_US;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ON_TIME:    timing_q.on_time_us    <= cfg.data;
				REG_OFF_TIME:   timing_q.off_time_us   <= cfg.data;
				REG_PAUSE_TIME: timing_q.pause_time_us <= cfg.data;
				default:        ;
			endcase
		end
	end

	// hold the sample until the result register has room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			now_s1  <= sample.now_us;
			code_s1 <= sample.fault_code;
		end
	end

	fbcs_step u_step (
		.cur        (state_q),
		.timing     (timing_q),
		.now_us     (now_s1),
		.fault_code (code_s1),
		.nxt        (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.code_seen   <= 1'b0;
			state_q.last_code   <= RST_LAST_CODE;
			state_q.pulses_left <= '0;
			state_q.seq_phase   <= PH_IDLE;
			state_q.mark_time   <= '0;
			state_q.led_level   <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			led_s2   <= state_nxt.led_level;
			phase_s2 <= state_nxt.seq_phase;
		end
	end

	assign result.valid  = valid_s2;
	assign result.led_on = led_s2;
	assign result.phase  = phase_s2;

	a_led_matches_phase: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.led_level == (state_q.seq_phase == PH_ON))
		else $error("led level out of step with phase");

	a_pause_no_pulses: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.seq_phase == PH_PAUSE |-> state_q.pulses_left == '0)
		else $error("pulses left in pause");

	a_pulses_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.seq_phase == PH_ON || state_q.seq_phase == PH_OFF)
			|-> state_q.pulses_left != '0)
		else $error("no pulse count while blinking");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("state moved without an item");

	a_result_follows_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2 && led_s2 == state_q.led_level
			&& phase_s2 == state_q.seq_phase)
		else $error("result register differs from state");

endmodule

>>> rtl/fbcs_step.sv
module fbcs_step
	import fbcs_pkg::*;
(
	input  seq_state_t        cur,
	input  timing_t           timing,
	input  logic [TIME_W-1:0] now_us,
	input  logic [CODE_W-1:0] fault_code,
	output seq_state_t        nxt
);

	logic [TIME_W-1:0] elapsed;
	logic [TIME_W-1:0] span;
	logic              waited;

	// pick the wait of the current phase, then one subtract and compare
	always_comb begin
		case (cur.seq_phase)
			PH_ON:    span = timing.on_time_us;
			PH_OFF:   span = timing.off_time_us;
			PH_PAUSE: span = timing.pause_time_us;
			default:  span = timing.on_time_us;
		endcase
	end

	assign elapsed = now_us - cur.mark_time;
	assign waited  = (elapsed >= span);

	always_comb begin
		nxt = cur;
		if (!cur.code_seen || fault_code != cur.last_code) begin
			nxt.code_seen   = 1'b1;
			nxt.last_code   = fault_code;
			nxt.pulses_left = fault_code;
			nxt.mark_time   = now_us;
			nxt.seq_phase   = (fault_code == '0) ? PH_IDLE : PH_ON;
			nxt.led_level   = (fault_code != '0);
		end else if (fault_code == '0) begin
			nxt.led_level = 1'b0;
		end else begin
			case (cur.seq_phase)
				PH_ON: begin
					if (waited) begin
						nxt.led_level = 1'b0;
						nxt.mark_time = now_us;
						nxt.seq_phase = PH_OFF;
					end
				end
				PH_OFF: begin
					if (waited) begin
						nxt.mark_time = now_us;
						if (cur.pulses_left > CODE_W'(1)) begin
							nxt.pulses_left = cur.pulses_left - CODE_W'(1);
							nxt.led_level   = 1'b1;
							nxt.seq_phase   = PH_ON;
						end else begin
							nxt.pulses_left = '0;
							nxt.seq_phase   = PH_PAUSE;
						end
					end
				end
				PH_PAUSE: begin
					if (waited) begin
						nxt.pulses_left = fault_code;
						nxt.led_level   = 1'b1;
						nxt.mark_time   = now_us;
						nxt.seq_phase   = PH_ON;
					end
				end
				default: begin
					nxt.led_level = 1'b0;
				end
			endcase
		end
	end

endmodule

>>> test/fbcs_checker.sv
module fbcs_checker
	import fbcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	fbcs_sample_if      sample,
	fbcs_result_if      result,
	fbcs_cfg_if         cfg,
	output int unsigned mismatches,
	output int unsigned outstanding
);

	typedef struct packed {
		logic   led_on;
		phase_t phase;
	} blink_t;

	timing_t    timing;
	seq_state_t seq;
	blink_t     expected_blinks[$];

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic logic span_met(logic [TIME_W-1:0] now, logic [TIME_W-1:0] span);
		logic [TIME_W-1:0] elapsed;
		elapsed = now - seq.mark_time;
		return elapsed >= span;
	endfunction

	function automatic blink_t blink_step(logic [TIME_W-1:0] now, logic [CODE_W-1:0] code);
		blink_t level;
		if (!seq.code_seen || code != seq.last_code) begin
			seq.code_seen   = 1'b1;
			seq.last_code   = code;
			seq.pulses_left = code;
			seq.mark_time   = now;
			seq.seq_phase   = (code == '0) ? PH_IDLE : PH_ON;
			seq.led_level   = (code != '0);
		end else if (code == '0) begin
			seq.led_level = 1'b0;
		end else begin
			case (seq.seq_phase)
				PH_ON: begin
					if (span_met(now, timing.on_time_us)) begin
						seq.led_level = 1'b0;
						seq.mark_time = now;
						seq.seq_phase = PH_OFF;
					end
				end
				PH_OFF: begin
					if (span_met(now, timing.off_time_us)) begin
						seq.mark_time = now;
						if (seq.pulses_left > 8'd1) begin
							seq.pulses_left = seq.pulses_left - 8'd1;
							seq.led_level   = 1'b1;
							seq.seq_phase   = PH_ON;
						end else begin
							seq.pulses_left = '0;
							seq.seq_phase   = PH_PAUSE;
						end
					end
				end
				PH_PAUSE: begin
					if (span_met(now, timing.pause_time_us)) begin
						seq.pulses_left = code;
						seq.led_level   = 1'b1;
						seq.mark_time   = now;
						seq.seq_phase   = PH_ON;
					end
				end
				default: begin
					seq.led_level = 1'b0;
				end
			endcase
		end
		level.led_on = seq.led_level;
		level.phase  = seq.seq_phase;
		return level;
	endfunction

	// handshakes seen here complete at the following rising edge
	always @(negedge clk) begin
		blink_t want;
		if (!arst_n) begin
			timing.on_time_us    = RST_ON_TIME_US;
			timing.off_time_us   = RST_OFF_TIME_US;
			timing.pause_time_us = RST_PAUSE_TIME_US;
			seq.code_seen        = 1'b0;
			seq.last_code        = RST_LAST_CODE;
			seq.pulses_left      = '0;
			seq.seq_phase        = PH_IDLE;
			seq.mark_time        = '0;
			seq.led_level        = 1'b0;
			expected_blinks.delete();
			mismatches           = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_ON_TIME:    timing.on_time_us    = cfg.data;
					REG_OFF_TIME:   timing.off_time_us   = cfg.data;
					REG_PAUSE_TIME: timing.pause_time_us = cfg.data;
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				if (expected_blinks.size() == 0) begin
					report_mismatch("unexpected result, phase", int'(result.phase), -1);
				end else begin
					want = expected_blinks.pop_front();
					if (result.led_on !== want.led_on)
						report_mismatch("led_on", int'(result.led_on), int'(want.led_on));
					if (result.phase !== want.phase)
						report_mismatch("phase", int'(result.phase), int'(want.phase));
				end
			end
			if (sample.valid && sample.ready)
				expected_blinks.push_back(blink_step(sample.now_us, sample.fault_code));
		end
		outstanding = expected_blinks.size();
	end

endmodule

>>> test/tb_top.sv
module tb_top
	import fbcs_pkg::*;
;

	localparam logic [INDEX_W-1:0] REG_SPARE   = 2'd3;
	localparam logic [TIME_W-1:0]  TIME_MAX    = 32'hFFFF_FFFF;
	localparam int                 HOLD_CYCLES = 80;
	localparam int                 CYCLE_LIMIT = 500000;

	logic        clk;
	logic        arst_n;
	int unsigned mismatches;
	int unsigned outstanding;
	int          tx_idle_pct;
	int          rx_idle_pct;
	int          hold_req;
	int          hold_ack;
	int          hold_left;
	int          cycles;
	logic [TIME_W-1:0] t_now;

	fbcs_sample_if sample ();
	fbcs_result_if result ();
	fbcs_cfg_if    cfg ();

	fault_blink_code_sequencer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.result (result),
		.cfg    (cfg)
	);

	fbcs_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample      (sample),
		.result      (result),
		.cfg         (cfg),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// hold off for a long stretch on request, otherwise stall at random
	always @(posedge clk) begin
		if (hold_ack != hold_req) begin
			hold_ack  = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			result.ready <= 1'b0;
		end else begin
			result.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	task automatic offer_sample(input logic [TIME_W-1:0] now, input logic [CODE_W-1:0] code);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			sample.valid <= 1'b0;
			@(posedge clk);
		end
		sample.valid      <= 1'b1;
		sample.now_us     <= now;
		sample.fault_code <= code;
		do @(negedge clk); while (!sample.ready);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [TIME_W-1:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(negedge clk); while (!cfg.ready);
		@(posedge clk);
	endtask

	task automatic quiesce();
		sample.valid <= 1'b0;
		cfg.valid    <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_timing(input logic [TIME_W-1:0] on_us, input logic [TIME_W-1:0] off_us,
			input logic [TIME_W-1:0] dark_us);
		write_reg(REG_ON_TIME, on_us);
		write_reg(REG_OFF_TIME, off_us);
		write_reg(REG_PAUSE_TIME, dark_us);
		quiesce();
	endtask

	// mostly steady codes over advancing time, some short runs and noise
	task automatic run_phase(input int items, input logic [TIME_W-1:0] step_max,
			input int code_max);
		int sent;
		int shape;
		int run_len;
		logic [CODE_W-1:0] code;
		sent = 0;
		while (sent < items) begin
			shape = $urandom_range(0, 9);
			if (shape == 0) begin
				offer_sample($urandom, CODE_W'($urandom_range(0, 255)));
				sent++;
			end else begin
				if (shape == 1) begin
					code    = CODE_W'($urandom_range(0, 255));
					run_len = $urandom_range(1, 3);
				end else begin
					code    = CODE_W'($urandom_range(1, code_max));
					run_len = $urandom_range(10, 60);
				end
				repeat (run_len) begin
					t_now = t_now + $urandom_range(0, step_max);
					offer_sample(t_now, code);
					sent++;
				end
			end
		end
		quiesce();
	endtask

	initial begin
		arst_n            = 1'b0;
		sample.valid      = 1'b0;
		sample.now_us     = '0;
		sample.fault_code = '0;
		cfg.valid         = 1'b0;
		cfg.index         = '0;
		cfg.data          = '0;
		tx_idle_pct       = 0;
		rx_idle_pct       = 0;
		hold_req          = 0;
		t_now             = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// first item after reset restarts even with code 255; wrapping elapsed time
		offer_sample(TIME_MAX, 8'd255);
		offer_sample(32'd119998, 8'd255);
		offer_sample(32'd119999, 8'd255);
		offer_sample(32'd239998, 8'd255);
		offer_sample(32'd239999, 8'd255);
		offer_sample(32'd0, 8'd0);
		offer_sample(32'd5, 8'd0);
		offer_sample(32'd1000, 8'd1);
		offer_sample(32'd121000, 8'd1);
		offer_sample(32'd241000, 8'd1);
		offer_sample(32'd841000, 8'd1);
		offer_sample(32'd841000, 8'd0);
		quiesce();

		// zero waits advance every item; spare index is ignored
		write_reg(REG_SPARE, TIME_MAX);
		set_timing('0, '0, '0);
		repeat (6) offer_sample(32'd7, 8'd2);
		offer_sample(32'd7, 8'd0);
		quiesce();

		set_timing(TIME_MAX, TIME_MAX, TIME_MAX);
		offer_sample(32'd100, 8'd3);
		offer_sample(32'd99, 8'd3);
		offer_sample(32'd98, 8'd3);
		offer_sample(32'd0, 8'd3);
		offer_sample(32'd200, 8'd128);
		offer_sample(32'd200, 8'd0);
		quiesce();

		tx_idle_pct = 17;
		rx_idle_pct = 84;
		set_timing(32'd3, 32'd2, 32'd7);
		run_phase(250, 32'd3, 5);
		set_timing(32'd1, 32'd1, 32'd1);
		t_now = 32'hFFFF_FF80;
		run_phase(250, 32'd2, 4);

		tx_idle_pct = 84;
		rx_idle_pct = 17;
		set_timing(32'd20, 32'd0, 32'd50);
		run_phase(250, 32'd8, 6);
		set_timing(RST_ON_TIME_US, RST_OFF_TIME_US, RST_PAUSE_TIME_US);
		run_phase(250, 32'd90000, 3);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_timing(32'd5, 32'd3, 32'd11);
		hold_req = hold_req + 1;
		run_phase(250, 32'd4, 6);
		set_timing(TIME_MAX, TIME_MAX, TIME_MAX);
		run_phase(250, TIME_MAX, 8);

		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
